// ===== hw/rtl/rwgf_pkg.sv =====
`timescale 1ns / 1ps
package rwgf_pkg;

  localparam int CoordW = 32;
  localparam int CfgW = 18;
  localparam int CfgIdxW = 2;
  localparam int UnitW = 32;  // signed Q2.30, magnitude at most 2^30
  localparam int NormW = 31;  // integer square root of a sum below 2^62
  localparam int MagW = 30;   // normalized magnitude below 2^30
  localparam int QuoW = 31;   // unit component magnitude up to 2^30
  localparam int SqrtSteps = 31;
  localparam int DivSteps = 31;
  // Normalize stage, sum-of-squares stage, then the root and quotient bits.
  localparam int UnitDepth = 2 + SqrtSteps + DivSteps;

  localparam logic [CfgIdxW-1:0] CfgHAlong = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgHAcross = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDummyOffset = 2'd2;

  localparam logic [CfgW-1:0] HAlongReset = 18'd38396;
  localparam logic [CfgW-1:0] HAcrossReset = 18'd49608;
  localparam logic [CfgW-1:0] DummyOffsetReset = 18'd15751;

  typedef logic signed [UnitW-1:0] unit_t;
  typedef unit_t [2:0] uvec_t;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0] cvec_t;

  typedef struct packed {
    cvec_t h1;
    cvec_t h2;
    cvec_t site;
    logic degenerate;
  } result_t;

  // Ties away from zero, division by 2^30.
  function automatic logic signed [63:0] rnd30(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] r;
    mag = x[63] ? (64'd0 - x) : x;
    r = (mag + 64'h2000_0000) >> 30;
    rnd30 = x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic coord_t sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) sat32 = 32'sh7fff_ffff;
    else if (x < -64'sd2147483648) sat32 = 32'sh8000_0000;
    else sat32 = x[31:0];
  endfunction

endpackage

// ===== hw/rtl/rigid_water_geometry_fix_unit.sv =====
`timescale 1ns / 1ps
// Rigid water geometry fix. Each request carries one water molecule (oxygen
// and two hydrogens, signed Q16.16) and yields one result: both rebuilt
// hydrogens, the dummy charge site and a degenerate flag. The unit is fully
// pipelined and accepts one request per cycle unless the result side stalls.
// A request passes through 64 stages for the bisector and hydrogen
// unit-vector pipelines running side by side, three dot-product stages, 64
// more for the unit vector of the in-plane direction, one placement stage
// and the output register.
// A stall on the result side freezes the whole pipeline; nothing is lost.
// Configuration registers may only be written while the unit is idle.
module rigid_water_geometry_fix_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rwgf_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [rwgf_pkg::CfgW-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [31:0]             in_oxy_x,
  input  logic signed [31:0]             in_oxy_y,
  input  logic signed [31:0]             in_oxy_z,
  input  logic signed [31:0]             in_hyd1_x,
  input  logic signed [31:0]             in_hyd1_y,
  input  logic signed [31:0]             in_hyd1_z,
  input  logic signed [31:0]             in_hyd2_x,
  input  logic signed [31:0]             in_hyd2_y,
  input  logic signed [31:0]             in_hyd2_z,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [31:0]             out_new_h1_x,
  output logic signed [31:0]             out_new_h1_y,
  output logic signed [31:0]             out_new_h1_z,
  output logic signed [31:0]             out_new_h2_x,
  output logic signed [31:0]             out_new_h2_y,
  output logic signed [31:0]             out_new_h2_z,
  output logic signed [31:0]             out_site_x,
  output logic signed [31:0]             out_site_y,
  output logic signed [31:0]             out_site_z,
  output logic                           out_degenerate
);
  import rwgf_pkg::*;

  logic [CfgW-1:0] h_along_r, h_across_r, dummy_offset_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_along_r <= HAlongReset;
      h_across_r <= HAcrossReset;
      dummy_offset_r <= DummyOffsetReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        CfgHAlong: h_along_r <= cfg_wdata;
        CfgHAcross: h_across_r <= cfg_wdata;
        CfgDummyOffset: dummy_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances when the output register is empty or its result is taken.
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // The oxygen rides along as the tag of the bisector and in-plane pipelines.
  localparam int TagW = 3 * CoordW;
  logic signed [2:0][33:0] s_vec, d_vec;
  logic [TagW-1:0] o_tag;
  always_comb begin
    s_vec[0] = 34'(in_hyd1_x) + 34'(in_hyd2_x) - (34'(in_oxy_x) <<< 1);
    s_vec[1] = 34'(in_hyd1_y) + 34'(in_hyd2_y) - (34'(in_oxy_y) <<< 1);
    s_vec[2] = 34'(in_hyd1_z) + 34'(in_hyd2_z) - (34'(in_oxy_z) <<< 1);
    d_vec[0] = 34'(in_hyd2_x) - 34'(in_hyd1_x);
    d_vec[1] = 34'(in_hyd2_y) - 34'(in_hyd1_y);
    d_vec[2] = 34'(in_hyd2_z) - 34'(in_hyd1_z);
    o_tag = {in_oxy_z, in_oxy_y, in_oxy_x};
  end

  logic u_vld, u_zero, v0_zero, v0_vld;
  uvec_t u_vec, v0_vec;
  logic [TagW-1:0] u_tag;
  logic [0:0] v0_tag;

  rwgf_unitize #(.InW(34), .TagW(TagW)) u_bis (
    .clk, .rst_n, .en, .in_vld(in_valid && in_ready), .in_vec(s_vec), .in_tag(o_tag),
    .out_vld(u_vld), .out_u(u_vec), .out_zero(u_zero), .out_tag(u_tag));
  rwgf_unitize #(.InW(34), .TagW(1)) u_hh (
    .clk, .rst_n, .en, .in_vld(in_valid && in_ready), .in_vec(d_vec), .in_tag(1'b0),
    .out_vld(v0_vld), .out_u(v0_vec), .out_zero(v0_zero), .out_tag(v0_tag));

  // Dot stages: three products registered, then summed and rounded, then the projection onto u.
  logic [2:0] p1_vld_r;
  logic signed [2:0][63:0] prod_r;
  uvec_t u1_r, v1_r, u2_r, v2_r;
  logic [TagW-1:0] t1_r, t2_r;
  logic bad1_r, bad2_r;
  logic signed [31:0] dot30_r;
  logic signed [2:0][63:0] pw_r;
  uvec_t u3_r, v3_r;
  logic [TagW-1:0] t3_r;
  logic bad3_r;
  logic signed [2:0][33:0] w_vec;
  always_comb begin
    for (int i = 0; i < 3; i++) w_vec[i] = 34'(v3_r[i]) - 34'(rnd30(pw_r[i]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) p1_vld_r <= '0;
    else if (en) p1_vld_r <= {p1_vld_r[1:0], u_vld};
    if (en) begin
      for (int i = 0; i < 3; i++) prod_r[i] <= 64'(v0_vec[i]) * 64'(u_vec[i]);
      u1_r <= u_vec; v1_r <= v0_vec; t1_r <= u_tag;
      bad1_r <= u_zero || v0_zero || v0_tag[0];
      dot30_r <= 32'(rnd30(prod_r[0] + prod_r[1] + prod_r[2]));
      u2_r <= u1_r; v2_r <= v1_r; t2_r <= t1_r; bad2_r <= bad1_r;
      for (int i = 0; i < 3; i++) pw_r[i] <= 64'(dot30_r) * 64'(u2_r[i]);
      u3_r <= u2_r; v3_r <= v2_r; t3_r <= t2_r; bad3_r <= bad2_r;
    end
  end

  // u delay line matched to the second unit-vector pipeline.
  localparam int VDepth = UnitDepth;
  uvec_t ud_r [VDepth];
  logic bd_r [VDepth];
  always_ff @(posedge clk) begin
    if (en) begin
      ud_r[0] <= u3_r;
      bd_r[0] <= bad3_r;
      for (int j = 1; j < VDepth; j++) begin
        ud_r[j] <= ud_r[j-1];
        bd_r[j] <= bd_r[j-1];
      end
    end
  end

  logic w_vld, w_zero;
  uvec_t v_vec;
  logic [TagW-1:0] w_tag;
  rwgf_unitize #(.InW(34), .TagW(TagW)) u_w (
    .clk, .rst_n, .en, .in_vld(p1_vld_r[2]), .in_vec(w_vec), .in_tag(t3_r),
    .out_vld(w_vld), .out_u(v_vec), .out_zero(w_zero), .out_tag(w_tag));

  // Placement: products, then round, add and saturate into the output reg.
  logic pl_vld_r;
  logic signed [2:0][63:0] al_r, ac_r, dm_r;
  cvec_t o_r;
  logic bad_r;
  always_ff @(posedge clk) begin
    if (!rst_n) pl_vld_r <= 1'b0;
    else if (en) pl_vld_r <= w_vld;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        al_r[i] <= $signed({1'b0, h_along_r}) * ud_r[VDepth-1][i];
        ac_r[i] <= $signed({1'b0, h_across_r}) * v_vec[i];
        dm_r[i] <= $signed({1'b0, dummy_offset_r}) * ud_r[VDepth-1][i];
      end
      o_r <= w_tag;
      bad_r <= bd_r[VDepth-1] || w_zero;
    end
  end

  result_t res_nxt, res_r;
  always_comb begin
    res_nxt = '0;
    res_nxt.degenerate = bad_r;
    if (!bad_r) begin
      for (int i = 0; i < 3; i++) begin
        res_nxt.h1[i] = sat32(64'(o_r[i]) + rnd30(al_r[i] + ac_r[i]));
        res_nxt.h2[i] = sat32(64'(o_r[i]) + rnd30(al_r[i] - ac_r[i]));
        res_nxt.site[i] = sat32(64'(o_r[i]) + rnd30(dm_r[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= pl_vld_r;
    if (en) res_r <= res_nxt;
  end

  assign out_new_h1_x = res_r.h1[0];
  assign out_new_h1_y = res_r.h1[1];
  assign out_new_h1_z = res_r.h1[2];
  assign out_new_h2_x = res_r.h2[0];
  assign out_new_h2_y = res_r.h2[1];
  assign out_new_h2_z = res_r.h2[2];
  assign out_site_x = res_r.site[0];
  assign out_site_y = res_r.site[1];
  assign out_site_z = res_r.site[2];
  assign out_degenerate = res_r.degenerate;

  // A degenerate result carries all-zero positions.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_site_x == 0 && out_new_h1_x == 0)
    else $error("degenerate result with nonzero position");
  // The two unit-vector pipelines stay in lockstep.
  a_lockstep: assert property (@(posedge clk) disable iff (!rst_n) u_vld == v0_vld)
    else $error("bisector and hydrogen pipelines out of step");
  // A stalled result is held.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_site_x))
    else $error("stalled result changed");
endmodule

// ===== hw/rtl/rwgf_unitize.sv =====
`timescale 1ns / 1ps
// Pipelined unit-vector unit: normalize stage, sum-of-squares stage, one
// square-root bit per stage, one quotient bit per stage for all three
// components in parallel.
module rwgf_unitize #(
  parameter int InW = 34,
  parameter int TagW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic signed [2:0][InW-1:0] in_vec,
  input  logic [TagW-1:0]            in_tag,
  output logic                       out_vld,
  output rwgf_pkg::uvec_t            out_u,
  output logic                       out_zero,
  output logic [TagW-1:0]            out_tag
);
  import rwgf_pkg::*;

  localparam int ShW = $clog2(InW + 1) + 1;
  localparam int Depth = UnitDepth;
  localparam int RemW = NormW + 2;

  typedef struct packed {
    logic                   vld;
    logic                   zero;
    logic [2:0]             neg;
    logic [2:0][MagW-1:0]   mag;
    logic [63:0]            rad;   // square-root remainder / radicand
    logic [NormW-1:0]       root;
    logic [2:0][RemW-1:0]   rem;
    logic [2:0][QuoW-1:0]   quo;
    logic [TagW-1:0]        tag;
  } stg_t;

  stg_t pipe_r [Depth];

  // Normalize stage.
  logic [2:0][InW-1:0] mag_in;
  logic [InW-1:0] mmax;
  logic [ShW-1:0] msb;
  stg_t s0;
  always_comb begin
    s0 = '0;
    mmax = '0;
    msb = '0;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = in_vec[i][InW-1] ? (InW'(0) - in_vec[i]) : in_vec[i];
      mmax = mmax | mag_in[i];
    end
    for (int b = 0; b < InW; b++) if (mmax[b]) msb = ShW'(b);
    s0.vld = in_vld;
    s0.tag = in_tag;
    s0.zero = (mmax == '0);
    for (int i = 0; i < 3; i++) begin
      s0.neg[i] = in_vec[i][InW-1];
      if (msb >= ShW'(29)) s0.mag[i] = MagW'(mag_in[i] >> (msb - ShW'(29)));
      else s0.mag[i] = MagW'({{MagW{1'b0}}, mag_in[i]} << (ShW'(29) - msb));
    end
  end

  // Radicand: sum of the squared normalized magnitudes.
  function automatic stg_t sq_sum(input stg_t s);
    stg_t o;
    o = s;
    o.rad = 64'(s.mag[0]) * 64'(s.mag[0]) + 64'(s.mag[1]) * 64'(s.mag[1])
          + 64'(s.mag[2]) * 64'(s.mag[2]);
    return o;
  endfunction

  // Restoring square-root step on rad; rem stays free during this phase.
  function automatic stg_t sqrt_step(input stg_t s, input int k);
    stg_t o;
    logic [65:0] trial;
    logic [65:0] part;
    o = s;
    part = 66'(s.rad) >> (2 * k);
    trial = {64'(s.root), 2'b01};
    if (part >= trial) begin
      o.rad = s.rad - 64'(trial << (2 * k));
      o.root = {s.root[NormW-2:0], 1'b1};
    end else begin
      o.root = {s.root[NormW-2:0], 1'b0};
    end
    return o;
  endfunction

  // Numerator N = mag*2^30 + floor(n/2) < 2^61. Quotient < 2^31, so the
  // initial partial remainder is floor(N / 2^30) and the remaining 30 low
  // bits of N are floor(n/2) mod 2^30 fed in one per step.
  function automatic stg_t div_seed(input stg_t s);
    stg_t o;
    logic [63:0] num;
    logic [RemW-1:0] r;
    o = s;
    for (int i = 0; i < 3; i++) begin
      num = (64'(s.mag[i]) << 30) + 64'(s.root >> 1);
      o.rad = num;  // not read by later steps; they take the low bits from mag
      r = RemW'(num >> 30);
      if (r >= RemW'(s.root)) begin
        o.rem[i] = r - RemW'(s.root);
        o.quo[i] = QuoW'(1);
      end else begin
        o.rem[i] = r;
        o.quo[i] = '0;
      end
      o.mag[i] = MagW'(num[29:0]);
    end
    return o;
  endfunction

  // Restoring division step: (mag*2^30 + n/2) / n, one quotient bit. The
  // next numerator bit comes from the low bits kept in mag by the seed.
  function automatic stg_t div_step(input stg_t s, input int k);
    stg_t o;
    logic [RemW-1:0] r;
    o = s;
    for (int i = 0; i < 3; i++) begin
      r = {s.rem[i][RemW-2:0], s.mag[i][k]};
      if (r >= RemW'(s.root)) begin
        o.rem[i] = r - RemW'(s.root);
        o.quo[i] = {s.quo[i][QuoW-2:0], 1'b1};
      end else begin
        o.rem[i] = r;
        o.quo[i] = {s.quo[i][QuoW-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < Depth; j++) pipe_r[j].vld <= 1'b0;
    end else if (en) begin
      pipe_r[0] <= s0;
      pipe_r[1] <= sq_sum(pipe_r[0]);
      for (int j = 2; j <= SqrtSteps + 1; j++)
        pipe_r[j] <= sqrt_step(pipe_r[j-1], SqrtSteps + 1 - j);
      pipe_r[SqrtSteps+2] <= div_seed(pipe_r[SqrtSteps+1]);
      for (int j = SqrtSteps + 3; j < Depth; j++)
        pipe_r[j] <= div_step(pipe_r[j-1], Depth - 1 - j);
    end
  end

  stg_t last;
  always_comb begin
    last = pipe_r[Depth-1];
    out_vld = last.vld;
    out_zero = last.zero;
    out_tag = last.tag;
    for (int i = 0; i < 3; i++)
      out_u[i] = last.neg[i] ? -$signed({1'b0, last.quo[i]}) : $signed({1'b0, last.quo[i]});
  end
endmodule
